// ----- rtl/dss_pkg.sv -----
// shared types and constants for the daily schedule selector
// no dependencies; used by dss_ctrl, dss_datapath and the top level
`timescale 1ns / 1ps

package dss_pkg;

    localparam logic [16:0] DAY_SECONDS = 17'd86400;

    typedef enum logic [1:0] {
        OP_TICK      = 2'd0,
        OP_LOAD      = 2'd1,
        OP_SET_TIME  = 2'd2,
        OP_SET_VALUE = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_LAST,
        S_PICK,
        S_EMIT
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic wr_start;
        logic wr_level;
        logic set_valid;
        logic scan_clear;
        logic scan_rd;
        logic sel_update;
        logic load_out;
    } t_ctrl_cmd;

    // status from datapath to controller
    typedef struct packed {
        t_op  op;
        logic slot_ok;
        logic entry_ok;
        logic sel_match;
        logic scan_last;
        logic found;
        logic best_is_sel;
        logic out_free;
    } t_dp_status;

endpackage

// ----- rtl/daily_schedule_selector_core.sv -----
// Daily schedule selector, top level.
// Input channel (i_in_valid / o_in_stall) carries one operation: tick with the
// second of day, load entry, set entry time or set entry value. A transfer
// happens at a clock edge with valid high and stall low.
// Output channel (o_out_valid / i_out_stall) carries the level now in force and
// its slot; at most one result per item.
// Load and set operations are captured in S_IDLE and executed in S_EXEC; a set value
// on the selected entry then passes S_EMIT, which loads the output register. A tick
// scans the start table one entry per cycle through its single read port (S_SCAN),
// then passes S_LAST and S_PICK, and S_EMIT when it emits.
// While the receiver stalls, the result waits in the output register; the
// block keeps taking items, and an item with a new result holds it, with the
// input stalled, until the register frees.
// Reset clears the valid bits and the selection; table contents are undefined
// until loaded, and no clearing pass runs.
// Depends on dss_pkg, dss_ctrl and dss_datapath.
`timescale 1ns / 1ps

module daily_schedule_selector_core #(
    parameter int ENTRIES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_operation,
    input  logic [3:0]         i_slot,
    input  logic [16:0]        i_seconds,
    input  logic signed [31:0] i_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_out_value,
    output logic [3:0]         o_out_slot
);

    dss_pkg::t_ctrl_cmd  cmd;
    dss_pkg::t_dp_status sts;

    dss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    dss_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_operation (i_operation),
        .i_slot      (i_slot),
        .i_seconds   (i_seconds),
        .i_value     (i_value),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_value (o_out_value),
        .o_out_slot  (o_out_slot)
    );

endmodule

// ----- rtl/dss_datapath.sv -----
// datapath: item registers, entry tables, scan compare, selection and output register
// depends on dss_pkg
`timescale 1ns / 1ps

module dss_datapath #(
    parameter int ENTRIES = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  dss_pkg::t_ctrl_cmd       i_cmd,
    output dss_pkg::t_dp_status      o_sts,
    input  logic [1:0]               i_operation,
    input  logic [3:0]               i_slot,
    input  logic [16:0]              i_seconds,
    input  logic signed [31:0]       i_value,
    input  logic                     i_out_stall,
    output logic                     o_out_valid,
    output logic signed [31:0]       o_out_value,
    output logic [3:0]               o_out_slot
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    function automatic logic [16:0] day_reduce(input logic [16:0] s);
        return (s >= dss_pkg::DAY_SECONDS) ? s - dss_pkg::DAY_SECONDS : s;
    endfunction

    // captured item
    dss_pkg::t_op       r_op;
    logic [3:0]         r_slot;
    logic [16:0]        r_secs;
    logic signed [31:0] r_val;

    // entry tables
    logic [16:0]        mem_start [ENTRIES];
    logic signed [31:0] mem_level [ENTRIES];
    logic [ENTRIES-1:0] r_valid;

    // scan
    logic [IDX_W-1:0]   r_scan_cnt;
    logic               r_cmp_en;
    logic               r_rd_vld;
    logic [IDX_W-1:0]   r_rd_idx;
    logic [16:0]        r_rd_start;
    logic signed [31:0] r_rd_level;
    logic [16:0]        r_best;
    logic [IDX_W-1:0]   r_best_idx;
    logic               r_found;

    // selection
    logic [IDX_W-1:0]   r_sel_slot;
    logic               r_sel_valid;

    // output register
    logic               r_out_valid;
    logic signed [31:0] r_out_value;
    logic [3:0]         r_out_slot;

    logic [IDX_W-1:0]   slot_idx;
    logic [16:0]        now;
    logic [16:0]        st;
    logic [16:0]        gap_wrap;
    logic [16:0]        gap;

    assign slot_idx = IDX_W'(r_slot);
    assign now      = day_reduce(r_secs);
    assign st       = day_reduce(r_rd_start);
    // only used when now < st, so the result fits in 17 bits
    assign gap_wrap = now + dss_pkg::DAY_SECONDS - st;
    assign gap      = (now >= st) ? now - st : gap_wrap;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= dss_pkg::t_op'(i_operation);
            r_slot <= i_slot;
            r_secs <= i_seconds;
            r_val  <= i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_start) begin
            mem_start[slot_idx] <= r_secs;
        end
        if (i_cmd.wr_level) begin
            mem_level[slot_idx] <= r_val;
        end
        if (i_cmd.scan_rd) begin
            r_rd_start <= mem_start[r_scan_cnt];
        end
        r_rd_level <= mem_level[r_best_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.set_valid) begin
            r_valid[slot_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_cnt <= '0;
            r_cmp_en   <= 1'b0;
            r_rd_vld   <= 1'b0;
            r_found    <= 1'b0;
        end else begin
            r_cmp_en <= i_cmd.scan_rd;
            r_rd_vld <= i_cmd.scan_rd && r_valid[r_scan_cnt];
            if (i_cmd.scan_clear) begin
                r_scan_cnt <= '0;
            end else if (i_cmd.scan_rd) begin
                r_scan_cnt <= r_scan_cnt + 1'b1;
            end
            if (i_cmd.scan_clear) begin
                r_found <= 1'b0;
            end else if (r_cmp_en && r_rd_vld && (!r_found || gap <= r_best)) begin
                r_found <= 1'b1;
            end
        end
    end

    // ties go to the later slot, hence <=
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_rd) begin
            r_rd_idx <= r_scan_cnt;
        end
        if (r_cmp_en && r_rd_vld && (!r_found || gap <= r_best)) begin
            r_best     <= gap;
            r_best_idx <= r_rd_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel_slot  <= '0;
            r_sel_valid <= 1'b0;
        end else if (i_cmd.sel_update) begin
            r_sel_slot  <= r_best_idx;
            r_sel_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // a tick announces the table level, a set value announces the new value
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            if (r_op == dss_pkg::OP_TICK) begin
                r_out_value <= r_rd_level;
                r_out_slot  <= 4'(r_best_idx);
            end else begin
                r_out_value <= r_val;
                r_out_slot  <= r_slot;
            end
        end
    end

    assign o_sts.op          = r_op;
    assign o_sts.slot_ok     = (32'(r_slot) < ENTRIES);
    assign o_sts.entry_ok    = r_valid[slot_idx];
    assign o_sts.sel_match   = r_sel_valid && (r_sel_slot == slot_idx);
    assign o_sts.scan_last   = (r_scan_cnt == IDX_W'(ENTRIES - 1));
    assign o_sts.found       = r_found;
    assign o_sts.best_is_sel = r_sel_valid && (r_sel_slot == r_best_idx);
    assign o_sts.out_free    = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_value = r_out_value;
    assign o_out_slot  = r_out_slot;

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_out_valid || !i_out_stall))
        else $error("output register overwritten while stalled");

    a_select_needs_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sel_update |-> r_found)
        else $error("selection updated without a valid entry");

    a_sel_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sel_update |=> (r_sel_valid && r_sel_slot == $past(r_best_idx)))
        else $error("selection register not updated");

    a_no_write_on_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.capture |-> !(i_cmd.wr_start || i_cmd.wr_level || i_cmd.scan_rd))
        else $error("table access while taking a new item");

endmodule

// ----- rtl/dss_ctrl.sv -----
// controller state machine: decodes the captured item and sequences the table scan
// depends on dss_pkg
`timescale 1ns / 1ps

module dss_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  dss_pkg::t_dp_status  i_sts,
    output dss_pkg::t_ctrl_cmd   o_cmd
);

    dss_pkg::t_state r_state;
    dss_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dss_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            dss_pkg::S_IDLE: begin
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = dss_pkg::S_EXEC;
                end
            end
            dss_pkg::S_EXEC: begin
                n_state = dss_pkg::S_IDLE;
                unique case (i_sts.op)
                    dss_pkg::OP_TICK: begin
                        o_cmd.scan_clear = 1'b1;
                        n_state          = dss_pkg::S_SCAN;
                    end
                    dss_pkg::OP_LOAD: begin
                        if (i_sts.slot_ok) begin
                            o_cmd.wr_start  = 1'b1;
                            o_cmd.wr_level  = 1'b1;
                            o_cmd.set_valid = 1'b1;
                        end
                    end
                    dss_pkg::OP_SET_TIME: begin
                        o_cmd.wr_start = i_sts.slot_ok && i_sts.entry_ok;
                    end
                    dss_pkg::OP_SET_VALUE: begin
                        if (i_sts.slot_ok && i_sts.entry_ok) begin
                            o_cmd.wr_level = 1'b1;
                            // new level of the entry in force goes out through S_EMIT
                            if (i_sts.sel_match) begin
                                n_state = dss_pkg::S_EMIT;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            dss_pkg::S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = dss_pkg::S_LAST;
                end
            end
            dss_pkg::S_LAST: begin
                // last compare lands this cycle
                n_state = dss_pkg::S_PICK;
            end
            dss_pkg::S_PICK: begin
                if (i_sts.found && !i_sts.best_is_sel) begin
                    o_cmd.sel_update = 1'b1;
                    n_state          = dss_pkg::S_EMIT;
                end else begin
                    n_state = dss_pkg::S_IDLE;
                end
            end
            dss_pkg::S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = dss_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dss_pkg::S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != dss_pkg::S_IDLE);

endmodule

// ----- sim/tb_top.sv -----
// self-checking testbench for daily_schedule_selector_core
// depends on dss_pkg and the rtl top level; a scoreboard class predicts announcements
`timescale 1ns / 1ps

module tb_top;

    localparam int ENTRIES     = 16;
    localparam int DAY         = 86400;
    localparam int HOLD_CYCLES = 600;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = ENTRIES + 12;

    typedef struct {
        logic signed [31:0] value;
        logic [3:0]         slot;
    } t_announcement;

    // mirrors the schedule table and queues the announcements it predicts
    class schedule_tracker;
        logic [16:0]        start_of[ENTRIES];
        logic signed [31:0] level_of[ENTRIES];
        bit                 loaded[ENTRIES];
        logic [3:0]         sel_slot;
        bit                 sel_valid;
        t_announcement      due_q[$];
        int                 errors;

        function new();
            for (int i = 0; i < ENTRIES; i++) begin
                start_of[i] = '0;
                level_of[i] = '0;
                loaded[i]   = 1'b0;
            end
            sel_slot  = '0;
            sel_valid = 1'b0;
            errors    = 0;
        endfunction

        function int fold_day(logic [16:0] s);
            return (int'(s) >= DAY) ? int'(s) - DAY : int'(s);
        endfunction

        function void take_item(dss_pkg::t_op op, logic [3:0] slot, logic [16:0] secs,
                                logic signed [31:0] val);
            t_announcement a;
            int            now;
            int            st;
            int            gap;
            int            best;
            int            best_slot;
            bit            found;
            if (op == dss_pkg::OP_TICK) begin
                now       = fold_day(secs);
                found     = 1'b0;
                best      = 0;
                best_slot = 0;
                for (int i = 0; i < ENTRIES; i++) begin
                    if (loaded[i]) begin
                        st  = fold_day(start_of[i]);
                        gap = (now >= st) ? now - st : now + DAY - st;
                        // later slots win ties
                        if (!found || gap <= best) begin
                            best      = gap;
                            best_slot = i;
                            found     = 1'b1;
                        end
                    end
                end
                if (!found || (sel_valid && int'(sel_slot) == best_slot))
                    return;
                sel_slot  = 4'(best_slot);
                sel_valid = 1'b1;
                a.value   = level_of[best_slot];
                a.slot    = 4'(best_slot);
                due_q.push_back(a);
                return;
            end
            if (int'(slot) >= ENTRIES)
                return;
            if (op == dss_pkg::OP_LOAD) begin
                start_of[slot] = secs;
                level_of[slot] = val;
                loaded[slot]   = 1'b1;
                return;
            end
            if (!loaded[slot])
                return;
            if (op == dss_pkg::OP_SET_TIME) begin
                start_of[slot] = secs;
                return;
            end
            level_of[slot] = val;
            if (sel_valid && sel_slot == slot) begin
                a.value = val;
                a.slot  = slot;
                due_q.push_back(a);
            end
        endfunction

        function void match_announcement(logic signed [31:0] got_value, logic [3:0] got_slot);
            t_announcement want;
            if (due_q.size() == 0) begin
                $error("unexpected transfer: out_value %0d out_slot %0d", got_value, got_slot);
                errors++;
                return;
            end
            want = due_q.pop_front();
            if (got_value !== want.value) begin
                $error("out_value: expected %0d, actual %0d", want.value, got_value);
                errors++;
            end
            if (got_slot !== want.slot) begin
                $error("out_slot: expected %0d, actual %0d", want.slot, got_slot);
                errors++;
            end
        endfunction

        function int pending();
            return due_q.size();
        endfunction
    endclass

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic [1:0]         i_operation = '0;
    logic [3:0]         i_slot      = '0;
    logic [16:0]        i_seconds   = '0;
    logic signed [31:0] i_value     = '0;
    logic               i_out_stall = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic signed [31:0] o_out_value;
    logic [3:0]         o_out_slot;

    schedule_tracker tracker = new();

    int idle_pct      = 0;
    int stall_pct     = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int cycle_count   = 0;

    daily_schedule_selector_core #(.ENTRIES(ENTRIES)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_operation (i_operation),
        .i_slot      (i_slot),
        .i_seconds   (i_seconds),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_value (o_out_value),
        .o_out_slot  (o_out_slot)
    );

    always #4 i_clk = ~i_clk;

    // receiver: random stall, or a long hold when one is requested
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            i_out_stall <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            hold_served <= hold_served + 1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            tracker.match_announcement(o_out_value, o_out_slot);
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic send_item(dss_pkg::t_op op, logic [3:0] slot, logic [16:0] secs,
                             logic signed [31:0] val);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_slot      <= slot;
        i_seconds   <= secs;
        i_value     <= val;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall)
                break;
        end
        tracker.take_item(op, slot, secs, val);
    endtask

    // drop valid and wait until every announcement has been checked
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0)
            @(posedge i_clk);
    endtask

    // bias toward the day boundary and repeated start times so ties occur
    function automatic logic [16:0] pick_seconds();
        case ($urandom_range(0, 9))
            0: return 17'd0;
            1: return 17'd86399;
            2: return 17'd86400 + 17'($urandom_range(0, 2));
            3: return 17'd131071;
            4: return 17'($urandom_range(0, 3) * 21600);
            default: return 17'($urandom_range(0, 131071));
        endcase
    endfunction

    task automatic random_items(int count);
        int                 r;
        dss_pkg::t_op       op;
        logic [3:0]         slot;
        logic signed [31:0] val;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 40)
                op = dss_pkg::OP_TICK;
            else if (r < 60)
                op = dss_pkg::OP_LOAD;
            else if (r < 72)
                op = dss_pkg::OP_SET_TIME;
            else
                op = dss_pkg::OP_SET_VALUE;
            slot = 4'($urandom_range(0, 15));
            if (op == dss_pkg::OP_SET_VALUE && tracker.sel_valid && $urandom_range(0, 1))
                slot = tracker.sel_slot;
            val = $urandom();
            send_item(op, slot, pick_seconds(), val);
        end
    endtask

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty table, then sets on entries never loaded, then a first load and ticks
        send_item(dss_pkg::OP_TICK,      4'd0,  17'd0,      32'sh1234_5678);
        send_item(dss_pkg::OP_SET_VALUE, 4'd5,  17'd0,      32'sh0001_0000);
        send_item(dss_pkg::OP_SET_TIME,  4'd5,  17'd77,     32'sh7FFF_FFFF);
        send_item(dss_pkg::OP_LOAD,      4'd0,  17'd0,      32'sh7FFF_FFFF);
        send_item(dss_pkg::OP_TICK,      4'd0,  17'd0,      32'sh8000_0000);
        send_item(dss_pkg::OP_TICK,      4'd9,  17'd50,     32'sh0);
        // equal start times once folded into the day: highest slot wins
        send_item(dss_pkg::OP_LOAD,      4'd15, 17'd86500,  32'sh8000_0000);
        send_item(dss_pkg::OP_LOAD,      4'd7,  17'd100,    -32'sd1);
        send_item(dss_pkg::OP_TICK,      4'd0,  17'd100,    32'sh0);
        send_item(dss_pkg::OP_SET_VALUE, 4'd15, 17'd0,      32'sh0001_0000);
        send_item(dss_pkg::OP_SET_VALUE, 4'd7,  17'd0,      32'sh1234_5678);
        send_item(dss_pkg::OP_SET_TIME,  4'd15, 17'd131071, 32'shFFFF_FFFF);
        send_item(dss_pkg::OP_TICK,      4'd0,  17'd200,    32'sh0);
        // reload of the selected entry stays silent
        send_item(dss_pkg::OP_LOAD,      4'd7,  17'd100,    32'sh5555_5555);
        send_item(dss_pkg::OP_TICK,      4'd3,  17'd300,    32'sh0);
        send_item(dss_pkg::OP_TICK,      4'd0,  17'd86399,  32'sh0);
        send_item(dss_pkg::OP_TICK,      4'd0,  17'd86400,  32'sh0);
        send_item(dss_pkg::OP_TICK,      4'd0,  17'd86401,  32'sh0);
        send_item(dss_pkg::OP_SET_VALUE, 4'd0,  17'd0,      32'sh0);
        send_item(dss_pkg::OP_TICK,      4'd0,  17'd44671,  32'sh0);
        send_item(dss_pkg::OP_LOAD,      4'd3,  17'd44671,  32'shA5A5_A5A5);
        send_item(dss_pkg::OP_TICK,      4'd0,  17'd44671,  32'sh0);
        send_item(dss_pkg::OP_SET_VALUE, 4'd15, 17'd1,      32'sh5A5A_5A5A);
        drain();

        random_items(350);
        drain();
        idle_pct = 75;
        random_items(300);
        drain();
        idle_pct  = 0;
        stall_pct = 75;
        random_items(300);
        drain();
        idle_pct  = 9;
        stall_pct = 9;
        random_items(300);
        drain();
        // long receiver hold while the sender keeps offering
        idle_pct  = 0;
        stall_pct = 0;
        hold_requests++;
        random_items(100);
        drain();

        repeat (SETTLE) @(posedge i_clk);
        if (tracker.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
